### src/led_matrix_framebuffer_scan_core_assert.svh
// Assertion macros for the LED matrix frame buffer scan core.
// Used by the port checker; expects signals named clk and rst_n in scope.
`ifndef LED_MATRIX_FRAMEBUFFER_SCAN_CORE_ASSERT_SVH
`define LED_MATRIX_FRAMEBUFFER_SCAN_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LMFS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lmfs check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define LMFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lmfs check failed in the following cycle");

`endif

### src/lmfs_pkg.sv
`timescale 1ns / 1ps
// Shared types, operation codes and default sizes of the LED matrix scan core.
// No dependencies.
package lmfs_pkg;

  localparam int DEFAULT_GRID_COLUMNS = 2;
  localparam int DEFAULT_GRID_ROWS    = 2;

  localparam logic [2:0] OP_SET       = 3'd0;
  localparam logic [2:0] OP_CLR       = 3'd1;
  localparam logic [2:0] OP_TGL       = 3'd2;
  localparam logic [2:0] OP_GET       = 3'd3;
  localparam logic [2:0] OP_REFRESH   = 3'd4;
  localparam logic [2:0] OP_CLEAR_ALL = 3'd5;

  typedef struct packed {
    logic [2:0] kind;
    logic       in_range;
    logic [5:0] x;
    logic [5:0] y;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } queue_head_t;

endpackage

### src/lmfs_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, decodes the command and range check, and queues them.
// Depends on lmfs_pkg.
module lmfs_front #(
  parameter int GRID_COLUMNS = lmfs_pkg::DEFAULT_GRID_COLUMNS,
  parameter int GRID_ROWS    = lmfs_pkg::DEFAULT_GRID_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_cmd,
  input  logic [5:0]            in_x,
  input  logic [5:0]            in_y,
  input  logic                  init_busy,
  input  logic                  pop,
  output lmfs_pkg::queue_head_t head
);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int PIX_COLS    = 8 * GRID_COLUMNS;
  localparam int PIX_ROWS    = 8 * GRID_ROWS;

  localparam logic [2:0] CMD_SET       = 3'd0;
  localparam logic [2:0] CMD_CLR       = 3'd1;
  localparam logic [2:0] CMD_TGL       = 3'd2;
  localparam logic [2:0] CMD_GET       = 3'd3;
  localparam logic [2:0] CMD_REFRESH   = 3'd4;
  localparam logic [2:0] CMD_CLEAR_ALL = 3'd5;

  lmfs_pkg::op_t     q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  lmfs_pkg::op_t     op_in;
  logic              push;
  logic              do_pop;

  always_comb begin
    op_in.x = in_x;
    op_in.y = in_y;
    op_in.in_range = (32'(in_x) < PIX_COLS) && (32'(in_y) < PIX_ROWS);
    unique case (in_cmd)
      CMD_SET:       op_in.kind = lmfs_pkg::OP_SET;
      CMD_CLR:       op_in.kind = lmfs_pkg::OP_CLR;
      CMD_TGL:       op_in.kind = lmfs_pkg::OP_TGL;
      CMD_GET:       op_in.kind = lmfs_pkg::OP_GET;
      CMD_REFRESH:   op_in.kind = lmfs_pkg::OP_REFRESH;
      CMD_CLEAR_ALL: op_in.kind = lmfs_pkg::OP_CLEAR_ALL;
      default:       op_in.kind = lmfs_pkg::OP_SET;
    endcase
  end

  assign in_stall   = (count_r == QCNT_W'(QUEUE_DEPTH)) || init_busy;
  assign push       = in_valid && !in_stall;
  assign head.valid = (count_r != '0);
  assign head.op    = q_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = QCNT_W'(count_r + 1'b1);
    end else if (do_pop && !push) begin
      count_nxt = QCNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= op_in;
    end
  end

endmodule

### src/lmfs_back.sv
`timescale 1ns / 1ps
// Back end: frame buffer memory, pixel read-modify-write, clear sweep, refresh scan
// and the output register. Depends on lmfs_pkg.
module lmfs_back #(
  parameter int GRID_COLUMNS = lmfs_pkg::DEFAULT_GRID_COLUMNS,
  parameter int GRID_ROWS    = lmfs_pkg::DEFAULT_GRID_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            position_map,
  input  logic [11:0]           orientation_map,
  input  lmfs_pkg::queue_head_t head,
  output logic                  pop,
  output logic                  init_busy,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_pixel_on,
  output logic [15:0]           out_spi_word,
  output logic                  out_word_valid,
  output logic                  out_frame_end,
  output logic                  out_last
);

  localparam int DEVICES   = GRID_COLUMNS * GRID_ROWS;
  localparam int BUF_BYTES = DEVICES * 8;
  localparam int AW        = $clog2(BUF_BYTES);
  localparam int DEV_W     = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int ROW_BYTES = 8 * GRID_COLUMNS;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_PIX   = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  logic [7:0]       mem [BUF_BYTES];
  logic [7:0]       rd_data_r;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_data;

  logic [2:0]       state_r, state_nxt;
  logic             init_r, init_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]    pix_addr_r, pix_addr_nxt;
  logic [2:0]       pix_bit_r, pix_bit_nxt;
  logic [2:0]       pix_kind_r, pix_kind_nxt;
  logic             pix_ok_r, pix_ok_nxt;
  logic [2:0]       digit_r, digit_nxt;
  logic [DEV_W-1:0] dev_r, dev_nxt;
  logic [3:0]       ld_cnt_r, ld_cnt_nxt;
  logic [3:0]       ld_prev;
  logic [7:0]       byte_r [8];
  logic [7:0]       byte_nxt [8];

  logic             out_valid_r, out_valid_nxt;
  logic             pixel_on_r, pixel_on_nxt;
  logic [15:0]      spi_word_r, spi_word_nxt;
  logic             word_valid_r, word_valid_nxt;
  logic             frame_end_r, frame_end_nxt;
  logic             last_r, last_nxt;
  logic             out_free;
  logic             out_load;

  logic [31:0]      head_addr32;
  logic [AW-1:0]    head_addr;
  logic [31:0]      dev32;
  logic [1:0]       slot2;
  logic [2:0]       code;
  logic [31:0]      slot32;
  logic             slot_ok;
  logic [31:0]      ld_addr32;
  logic [AW-1:0]    ld_addr;
  logic [2:0]       dsel;
  logic [7:0]       plain_b;
  logic [7:0]       gath_b;
  logic [7:0]       pre_b;
  logic [7:0]       disp_b;
  logic [7:0]       mask;
  logic [7:0]       new_b;
  logic             pix_on;

  assign init_busy = init_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign pop       = (state_r == ST_IDLE) && head.valid;

  assign head_addr32 = 32'(head.op.y[5:3]) * ROW_BYTES + 32'(head.op.x);
  assign head_addr   = head.op.in_range ? head_addr32[AW-1:0] : '0;

  always_comb begin
    dev32 = 32'(dev_r);
    slot2 = 2'd0;
    code  = 3'd0;
    unique case (dev32[1:0])
      2'd0: begin
        slot2 = position_map[1:0];
        code  = orientation_map[2:0];
      end
      2'd1: begin
        slot2 = position_map[3:2];
        code  = orientation_map[5:3];
      end
      2'd2: begin
        slot2 = position_map[5:4];
        code  = orientation_map[8:6];
      end
      default: begin
        slot2 = position_map[7:6];
        code  = orientation_map[11:9];
      end
    endcase
    if (dev32 < 32'd4) begin
      slot32 = 32'(slot2);
    end else begin
      slot32 = dev32;
      code   = 3'd0;
    end
    slot_ok   = slot32 < DEVICES;
    ld_addr32 = (slot32 << 3) | 32'(ld_cnt_r[2:0]);
    ld_addr   = ld_addr32[AW-1:0];
  end

  always_comb begin
    dsel    = code[0] ? 3'(3'd7 - digit_r) : digit_r;
    plain_b = byte_r[dsel];
    for (int i = 0; i < 8; i++) begin
      gath_b[i] = byte_r[i][dsel];
    end
    pre_b  = code[2] ? gath_b : plain_b;
    disp_b = code[1] ? rev8(pre_b) : pre_b;
    if (!slot_ok) begin
      disp_b = 8'h00;
    end
  end

  always_comb begin
    mask = 8'h01 << pix_bit_r;
    unique case (pix_kind_r)
      lmfs_pkg::OP_CLR: begin
        new_b  = rd_data_r & ~mask;
        pix_on = 1'b0;
      end
      lmfs_pkg::OP_TGL: begin
        new_b  = rd_data_r ^ mask;
        pix_on = |(new_b & mask);
      end
      lmfs_pkg::OP_GET: begin
        new_b  = rd_data_r;
        pix_on = |(rd_data_r & mask);
      end
      default: begin
        new_b  = rd_data_r | mask;
        pix_on = 1'b1;
      end
    endcase
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE: rd_addr = head_addr;
      ST_LOAD: rd_addr = ld_addr;
      default: rd_addr = pix_addr_r;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    init_nxt       = init_r;
    clr_addr_nxt   = clr_addr_r;
    pix_addr_nxt   = pix_addr_r;
    pix_bit_nxt    = pix_bit_r;
    pix_kind_nxt   = pix_kind_r;
    pix_ok_nxt     = pix_ok_r;
    digit_nxt      = digit_r;
    dev_nxt        = dev_r;
    ld_cnt_nxt     = ld_cnt_r;
    ld_prev        = 4'(ld_cnt_r - 4'd1);
    byte_nxt       = byte_r;
    wr_en          = 1'b0;
    wr_addr        = pix_addr_r;
    wr_data        = new_b;
    out_load       = 1'b0;
    pixel_on_nxt   = pixel_on_r;
    spi_word_nxt   = spi_word_r;
    word_valid_nxt = word_valid_r;
    frame_end_nxt  = frame_end_r;
    last_nxt       = last_r;

    unique case (state_r)
      ST_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        wr_data      = 8'h00;
        clr_addr_nxt = AW'(clr_addr_r + 1'b1);
        if (32'(clr_addr_r) == BUF_BYTES - 1) begin
          clr_addr_nxt = '0;
          if (init_r) begin
            init_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_IDLE: begin
        if (head.valid) begin
          pix_addr_nxt = head_addr;
          pix_bit_nxt  = head.op.y[2:0];
          pix_kind_nxt = head.op.kind;
          pix_ok_nxt   = head.op.in_range;
          digit_nxt    = 3'd0;
          dev_nxt      = DEV_W'(DEVICES - 1);
          ld_cnt_nxt   = 4'd0;
          clr_addr_nxt = '0;
          unique case (head.op.kind)
            lmfs_pkg::OP_REFRESH:   state_nxt = ST_LOAD;
            lmfs_pkg::OP_CLEAR_ALL: state_nxt = ST_CLEAR;
            default:                state_nxt = ST_PIX;
          endcase
        end
      end
      ST_PIX: begin
        if (out_free) begin
          wr_en          = pix_ok_r && (pix_kind_r != lmfs_pkg::OP_GET);
          out_load       = 1'b1;
          pixel_on_nxt   = pix_ok_r && pix_on;
          spi_word_nxt   = 16'h0000;
          word_valid_nxt = 1'b0;
          frame_end_nxt  = 1'b0;
          last_nxt       = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_LOAD: begin
        if (!slot_ok) begin
          state_nxt = ST_EMIT;
        end else begin
          if (ld_cnt_r != 4'd0) begin
            byte_nxt[ld_prev[2:0]] = rd_data_r;
          end
          if (ld_cnt_r == 4'd8) begin
            state_nxt = ST_EMIT;
          end else begin
            ld_cnt_nxt = 4'(ld_cnt_r + 4'd1);
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          pixel_on_nxt   = 1'b0;
          spi_word_nxt   = {4'h0, 4'(4'(digit_r) + 4'd1), disp_b};
          word_valid_nxt = 1'b1;
          frame_end_nxt  = (dev_r == '0);
          last_nxt       = (dev_r == '0) && (digit_r == 3'd7);
          ld_cnt_nxt     = 4'd0;
          state_nxt      = ST_LOAD;
          if (dev_r == '0) begin
            dev_nxt = DEV_W'(DEVICES - 1);
            if (digit_r == 3'd7) begin
              digit_nxt = 3'd0;
              dev_nxt   = '0;
              state_nxt = ST_IDLE;
            end else begin
              digit_nxt = 3'(digit_r + 3'd1);
            end
          end else begin
            dev_nxt = DEV_W'(dev_r - 1'b1);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load       = 1'b1;
          pixel_on_nxt   = 1'b0;
          spi_word_nxt   = 16'h0000;
          word_valid_nxt = 1'b0;
          frame_end_nxt  = 1'b0;
          last_nxt       = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      init_r      <= 1'b1;
      clr_addr_r  <= '0;
      digit_r     <= 3'd0;
      dev_r       <= '0;
      ld_cnt_r    <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      clr_addr_r  <= clr_addr_nxt;
      digit_r     <= digit_nxt;
      dev_r       <= dev_nxt;
      ld_cnt_r    <= ld_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_addr_r   <= pix_addr_nxt;
    pix_bit_r    <= pix_bit_nxt;
    pix_kind_r   <= pix_kind_nxt;
    pix_ok_r     <= pix_ok_nxt;
    byte_r       <= byte_nxt;
    pixel_on_r   <= pixel_on_nxt;
    spi_word_r   <= spi_word_nxt;
    word_valid_r <= word_valid_nxt;
    frame_end_r  <= frame_end_nxt;
    last_r       <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_on   = pixel_on_r;
  assign out_spi_word   = spi_word_r;
  assign out_word_valid = word_valid_r;
  assign out_frame_end  = frame_end_r;
  assign out_last       = last_r;

endmodule

### src/led_matrix_framebuffer_scan_core.sv
`timescale 1ns / 1ps
// Top level of the LED matrix frame buffer scan core: configuration registers,
// front end queue and back end. Depends on lmfs_pkg, lmfs_front and lmfs_back.
//
// Pixel commands (set, clear, toggle, get) take the item from the queue and read the
// buffer byte through the single memory read port, then write it back and register
// the result. A clear-all sweeps the 8*GRID_COLUMNS*GRID_ROWS bytes of the buffer at
// one byte a cycle, then registers its result. A refresh gives 8*GRID_COLUMNS*GRID_ROWS
// words; for each word of a placed device the back end reads that device's eight
// bytes through the registered read port and then emits the word, and a device whose
// slot lies beyond the grid skips the reads and gives a zero byte. A stalled result
// holds the back end until it leaves. After reset the buffer is cleared by the same
// sweep while in_stall is high; configuration writes are taken throughout. A two-entry
// queue sits between the input side and the buffer engine, and results leave through
// a register.
module led_matrix_framebuffer_scan_core #(
  parameter int GRID_COLUMNS = lmfs_pkg::DEFAULT_GRID_COLUMNS,
  parameter int GRID_ROWS    = lmfs_pkg::DEFAULT_GRID_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [5:0]  in_x,
  input  logic [5:0]  in_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_pixel_on,
  output logic [15:0] out_spi_word,
  output logic        out_word_valid,
  output logic        out_frame_end,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam logic [1:0]  CFG_POSITION_MAP    = 2'd0;
  localparam logic [1:0]  CFG_ORIENTATION_MAP = 2'd1;
  localparam logic [7:0]  POSITION_RESET      = 8'd120;
  localparam logic [11:0] ORIENTATION_RESET   = 12'd2934;

  logic [7:0]            position_map_r, position_map_nxt;
  logic [11:0]           orientation_map_r, orientation_map_nxt;
  lmfs_pkg::queue_head_t head;
  logic                  pop;
  logic                  init_busy;

  assign cfg_ready = 1'b1;

  always_comb begin
    position_map_nxt    = position_map_r;
    orientation_map_nxt = orientation_map_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POSITION_MAP:    position_map_nxt = cfg_data[7:0];
        CFG_ORIENTATION_MAP: orientation_map_nxt = cfg_data;
        default:             ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_map_r    <= POSITION_RESET;
      orientation_map_r <= ORIENTATION_RESET;
    end else begin
      position_map_r    <= position_map_nxt;
      orientation_map_r <= orientation_map_nxt;
    end
  end

  lmfs_front #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_x      (in_x),
    .in_y      (in_y),
    .init_busy (init_busy),
    .pop       (pop),
    .head      (head)
  );

  lmfs_back #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .position_map    (position_map_r),
    .orientation_map (orientation_map_r),
    .head            (head),
    .pop             (pop),
    .init_busy       (init_busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_on    (out_pixel_on),
    .out_spi_word    (out_spi_word),
    .out_word_valid  (out_word_valid),
    .out_frame_end   (out_frame_end),
    .out_last        (out_last)
  );

endmodule

### src/lmfs_checker.sv
`timescale 1ns / 1ps
// Port checker for the LED matrix frame buffer scan core, bound to the top level.
// Depends on led_matrix_framebuffer_scan_core_assert.svh.
`include "led_matrix_framebuffer_scan_core_assert.svh"

module lmfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_pixel_on,
  input logic [15:0] out_spi_word,
  input logic        out_word_valid,
  input logic        out_frame_end,
  input logic        out_last
);

  `LMFS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(out_spi_word) && $stable(out_last))
  `LMFS_ASSERT_NOW(a_single_result, out_valid && !out_word_valid,
                   out_spi_word == 16'h0000 && !out_frame_end && out_last)
  `LMFS_ASSERT_NOW(a_refresh_tail, out_valid && out_word_valid && out_last,
                   out_frame_end && out_spi_word[15:8] == 8'h08)
  `LMFS_ASSERT_NOW(a_word_digit, out_valid && out_word_valid,
                   !out_pixel_on && out_spi_word[15:8] != 8'h00 && out_spi_word[15:12] == 4'h0)

endmodule

bind led_matrix_framebuffer_scan_core lmfs_checker u_lmfs_checker (.*);

### tb/led_matrix_framebuffer_scan_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for led_matrix_framebuffer_scan_core: directed table, then
// random pixel, refresh and clear-all items over several register settings, checked
// against a frame buffer predictor held here. Depends on lmfs_pkg and the core only.
module led_matrix_framebuffer_scan_core_tb;

  localparam int COLS    = lmfs_pkg::DEFAULT_GRID_COLUMNS;
  localparam int ROWS    = lmfs_pkg::DEFAULT_GRID_ROWS;
  localparam int DEVICES = COLS * ROWS;
  localparam int LIMIT   = 400000;

  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam logic [1:0] REG_POSITION = 2'd0;
  localparam logic [1:0] REG_ORIENT   = 2'd1;
  localparam logic [1:0] REG_SPARE_2  = 2'd2;
  localparam logic [1:0] REG_SPARE_3  = 2'd3;

  typedef enum logic [2:0] {
    ORI_ROWS, ORI_ROWS_FLIP, ORI_ROWS_REV, ORI_ROWS_FLIP_REV,
    ORI_COLS, ORI_COLS_FLIP, ORI_COLS_REV, ORI_COLS_FLIP_REV
  } orient_e;

  typedef struct packed {
    logic        pixel_on;
    logic [15:0] spi_word;
    logic        word_valid;
    logic        frame_end;
    logic        last;
  } scan_result_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [5:0] x;
    logic [5:0] y;
    logic       typed;
    logic       pix;
  } probe_t;

  localparam probe_t PROBES [24] = '{
    '{lmfs_pkg::OP_GET,       6'd0,  6'd0,  1'b1, 1'b0},
    '{lmfs_pkg::OP_SET,       6'd0,  6'd0,  1'b1, 1'b1},
    '{lmfs_pkg::OP_GET,       6'd0,  6'd0,  1'b1, 1'b1},
    '{lmfs_pkg::OP_SET,       6'd15, 6'd15, 1'b1, 1'b1},
    '{lmfs_pkg::OP_SET,       6'd63, 6'd63, 1'b1, 1'b0},
    '{lmfs_pkg::OP_TGL,       6'd16, 6'd0,  1'b1, 1'b0},
    '{lmfs_pkg::OP_GET,       6'd0,  6'd16, 1'b1, 1'b0},
    '{lmfs_pkg::OP_TGL,       6'd7,  6'd9,  1'b1, 1'b1},
    '{lmfs_pkg::OP_TGL,       6'd7,  6'd9,  1'b1, 1'b0},
    '{lmfs_pkg::OP_CLR,       6'd15, 6'd15, 1'b1, 1'b0},
    '{CMD_SPARE_LO,           6'd3,  6'd4,  1'b1, 1'b1},
    '{CMD_SPARE_HI,           6'd12, 6'd10, 1'b1, 1'b1},
    '{lmfs_pkg::OP_SET,       6'd8,  6'd3,  1'b1, 1'b1},
    '{lmfs_pkg::OP_SET,       6'd5,  6'd12, 1'b1, 1'b1},
    '{lmfs_pkg::OP_REFRESH,   6'd63, 6'd63, 1'b0, 1'b0},
    '{lmfs_pkg::OP_GET,       6'd12, 6'd10, 1'b1, 1'b1},
    '{lmfs_pkg::OP_CLEAR_ALL, 6'd0,  6'd0,  1'b1, 1'b0},
    '{lmfs_pkg::OP_GET,       6'd3,  6'd4,  1'b1, 1'b0},
    '{lmfs_pkg::OP_REFRESH,   6'd0,  6'd0,  1'b0, 1'b0},
    '{lmfs_pkg::OP_SET,       6'd42, 6'd21, 1'b1, 1'b0},
    '{lmfs_pkg::OP_SET,       6'd9,  6'd6,  1'b0, 1'b0},
    '{lmfs_pkg::OP_REFRESH,   6'd21, 6'd42, 1'b0, 1'b0},
    '{lmfs_pkg::OP_GET,       6'd63, 6'd0,  1'b1, 1'b0},
    '{lmfs_pkg::OP_CLR,       6'd9,  6'd6,  1'b1, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_cmd = lmfs_pkg::OP_GET;
  logic [5:0]  in_x = '0;
  logic [5:0]  in_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_pixel_on;
  logic [15:0] out_spi_word;
  logic        out_word_valid;
  logic        out_frame_end;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_POSITION;
  logic [11:0] cfg_data = '0;

  logic [7:0]   pixels [8 * DEVICES];
  logic [7:0]   pos_map = 8'd120;
  logic [11:0]  orient_map = 12'd2934;
  scan_result_t fresh [$];
  scan_result_t awaited [$];
  bit           calm = 1'b0;
  bit           failed = 1'b0;
  int unsigned  cycles = 0;

  led_matrix_framebuffer_scan_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_x          (in_x),
    .in_y          (in_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_on  (out_pixel_on),
    .out_spi_word  (out_spi_word),
    .out_word_valid(out_word_valid),
    .out_frame_end (out_frame_end),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] bit_rev(logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7 - i] = v[i];
    return r;
  endfunction

  function automatic logic [7:0] column_slice(int off, int d);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = pixels[off + i][d];
    return r;
  endfunction

  function automatic logic [7:0] panel_byte(int dev, int d);
    int         slot;
    int         off;
    orient_e    code;
    logic [7:0] b;
    slot = pos_map[2 * dev +: 2];
    code = orient_e'(orient_map[3 * dev +: 3]);
    if (slot >= DEVICES) return 8'h00;
    off = (slot / COLS) * 8 * COLS + (slot % COLS) * 8;
    case (code)
      ORI_ROWS_FLIP:     b = pixels[off + 7 - d];
      ORI_ROWS_REV:      b = bit_rev(pixels[off + d]);
      ORI_ROWS_FLIP_REV: b = bit_rev(pixels[off + 7 - d]);
      ORI_COLS:          b = column_slice(off, d);
      ORI_COLS_FLIP:     b = column_slice(off, 7 - d);
      ORI_COLS_REV:      b = bit_rev(column_slice(off, d));
      ORI_COLS_FLIP_REV: b = bit_rev(column_slice(off, 7 - d));
      default:           b = pixels[off + d];
    endcase
    return b;
  endfunction

  function automatic void predict_scan(logic [2:0] cmd, logic [5:0] x, logic [5:0] y);
    scan_result_t r;
    int           addr;
    logic [7:0]   mask;
    fresh.delete();
    r = '0;
    if (cmd == lmfs_pkg::OP_REFRESH) begin
      for (int d = 0; d < 8; d++) begin
        for (int dev = DEVICES - 1; dev >= 0; dev--) begin
          r = '0;
          r.spi_word   = {8'(d + 1), panel_byte(dev, d)};
          r.word_valid = 1'b1;
          r.frame_end  = (dev == 0);
          r.last       = (d == 7 && dev == 0);
          fresh.push_back(r);
        end
      end
    end else begin
      r.last = 1'b1;
      if (cmd == lmfs_pkg::OP_CLEAR_ALL) begin
        foreach (pixels[i]) pixels[i] = 8'h00;
      end else if (x < 8 * COLS && y < 8 * ROWS) begin
        addr = (y / 8) * 8 * COLS + x;
        mask = 8'h01 << y[2:0];
        case (cmd)
          lmfs_pkg::OP_CLR: pixels[addr] = pixels[addr] & ~mask;
          lmfs_pkg::OP_TGL: pixels[addr] = pixels[addr] ^ mask;
          lmfs_pkg::OP_GET: ;
          default:          pixels[addr] = pixels[addr] | mask;
        endcase
        r.pixel_on = (pixels[addr] & mask) != 8'h00;
      end
      fresh.push_back(r);
    end
  endfunction

  task automatic push_item(logic [2:0] cmd, logic [5:0] x, logic [5:0] y,
                           logic typed, logic pix);
    scan_result_t r;
    if (!calm && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_x     <= x;
    in_y     <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_scan(cmd, x, y);
    if (typed) begin
      r          = '0;
      r.pixel_on = pix;
      r.last     = 1'b1;
      awaited.push_back(r);
    end else begin
      foreach (fresh[i]) awaited.push_back(fresh[i]);
    end
  endtask

  task automatic random_item();
    logic [2:0] cmd;
    logic [5:0] x;
    logic [5:0] y;
    int         roll;
    roll = $urandom_range(0, 99);
    if (roll < 8)       cmd = lmfs_pkg::OP_REFRESH;
    else if (roll < 11) cmd = lmfs_pkg::OP_CLEAR_ALL;
    else if (roll < 14) cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
    else if (roll < 50) cmd = lmfs_pkg::OP_SET;
    else if (roll < 65) cmd = lmfs_pkg::OP_CLR;
    else if (roll < 80) cmd = lmfs_pkg::OP_TGL;
    else                cmd = lmfs_pkg::OP_GET;
    if ($urandom_range(0, 99) < 85) begin
      x = $urandom_range(0, 8 * COLS - 1);
      y = $urandom_range(0, 8 * ROWS - 1);
    end else begin
      x = $urandom_range(0, 63);
      y = $urandom_range(0, 63);
    end
    push_item(cmd, x, y, 1'b0, 1'b0);
  endtask

  task automatic run_phase(int count, bit quiet);
    calm = quiet;
    repeat (count) random_item();
    in_valid <= 1'b0;
    calm = 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_POSITION: pos_map = data[7:0];
      REG_ORIENT:   orient_map = data;
      default:      ;
    endcase
  endtask

  initial begin : stimulus
    foreach (pixels[i]) pixels[i] = 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (PROBES[i])
      push_item(PROBES[i].cmd, PROBES[i].x, PROBES[i].y, PROBES[i].typed, PROBES[i].pix);
    run_phase(40, 1'b0);

    write_reg(REG_POSITION, 12'h000);
    write_reg(REG_ORIENT, 12'h000);
    cfg_valid <= 1'b0;
    run_phase(55, 1'b0);

    write_reg(REG_POSITION, 12'hFFF);
    write_reg(REG_ORIENT, 12'hFFF);
    cfg_valid <= 1'b0;
    run_phase(55, 1'b0);

    write_reg(REG_SPARE_2, 12'($urandom));
    write_reg(REG_POSITION, 12'($urandom));
    write_reg(REG_ORIENT, 12'($urandom));
    write_reg(REG_SPARE_3, 12'($urandom));
    cfg_valid <= 1'b0;
    run_phase(55, 1'b1);

    write_reg(REG_POSITION, 12'h0E4);
    write_reg(REG_ORIENT, 12'($urandom));
    cfg_valid <= 1'b0;
    run_phase(55, 1'b0);

    write_reg(REG_POSITION, 12'($urandom));
    write_reg(REG_ORIENT, 12'($urandom));
    cfg_valid <= 1'b0;
    run_phase(55, 1'b0);

    if (!failed) begin
      $display("PASS led_matrix_framebuffer_scan_core");
    end else begin
      $display("FAIL led_matrix_framebuffer_scan_core");
    end
    $finish;
  end

  always @(posedge clk) begin : result_check
    scan_result_t want;
    out_stall <= !calm && ($urandom_range(0, 99) < 9);
    if (rst_n && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        $error("result item arrived with nothing awaited");
        failed = 1'b1;
      end else begin
        want = awaited.pop_front();
        if (out_pixel_on !== want.pixel_on) begin
          $error("pixel_on: expected %0d, got %0d", want.pixel_on, out_pixel_on);
          failed = 1'b1;
        end
        if (out_spi_word !== want.spi_word) begin
          $error("spi_word: expected %h, got %h", want.spi_word, out_spi_word);
          failed = 1'b1;
        end
        if (out_word_valid !== want.word_valid) begin
          $error("word_valid: expected %0d, got %0d", want.word_valid, out_word_valid);
          failed = 1'b1;
        end
        if (out_frame_end !== want.frame_end) begin
          $error("frame_end: expected %0d, got %0d", want.frame_end, out_frame_end);
          failed = 1'b1;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAIL led_matrix_framebuffer_scan_core");
      $finish;
    end
  end

endmodule
